FILE: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared assertion wrappers for the coordinate mapper; empty under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: design/rfsc_pkg.sv
// ============================================================================
// Coordinate mapper package
// Default sizes, register map and orientation codes of the coordinate mapper.
// ============================================================================
package rfsc_pkg;

  // Default sizes.
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Width of the saturated source coordinates.
  localparam int unsigned OUT_W = 22;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from the word address.
  typedef enum logic [2:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_VIEW_X      = 3'd2,
    REG_VIEW_Y      = 3'd3,
    REG_VIEW_WIDTH  = 3'd4,
    REG_VIEW_HEIGHT = 3'd5,
    REG_ORIENT      = 3'd6
  } reg_idx_e;

  // Quarter turn codes in orientation bits 1:0.
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

endpackage

FILE: design/rfsc_div.sv
// ============================================================================
// Pipelined divider
// Restoring long division of (num << FRAC_BITS) by den, one quotient bit per
// register stage; a new transaction may enter every cycle.
// ============================================================================
`include "assert_macros.svh"

module rfsc_div #(
  parameter int unsigned NUM_W     = 2 * (rfsc_pkg::COORD_BITS_DEF + 1),
  parameter int unsigned DEN_W     = rfsc_pkg::COORD_BITS_DEF + 1,
  parameter int unsigned FRAC_BITS = rfsc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  output logic                         valid_o,
  output logic [NUM_W+FRAC_BITS-1:0]   quo_o
);

  localparam int unsigned QW = NUM_W + FRAC_BITS;

  // Per stage: valid bit, partial remainder, and a word whose upper part is
  // the dividend still to consume and whose lower part is the quotient so far.
  logic             valid_q [QW];
  logic [DEN_W-1:0] rem_q   [QW];
  logic [QW-1:0]    word_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0]    word_in;
    logic [DEN_W-1:0] rem_in;
    logic             vld_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_d;
    logic [QW-1:0]    word_d;

    // The first stage loads the scaled dividend, later stages chain.
    if (k == 0) begin : g_first
      assign word_in = {num_i, {FRAC_BITS{1'b0}}};
      assign rem_in  = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign word_in = word_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign vld_in  = valid_q[k-1];
    end

    // Bring down one dividend bit and subtract the divisor if it fits.
    assign trial  = {rem_in, word_in[QW-1]};
    assign ge     = (trial >= {1'b0, den_i});
    assign rem_d  = ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
    assign word_d = {word_in[QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      word_q[k] <= word_d;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = word_q[QW-1];

  // The final remainder of a finished division is always below the divisor.
  `ASSERT_IMPL(a_rem_below_den, clk_i, rst_ni, valid_o, rem_q[QW-1] < den_i, "remainder not below divisor")

endmodule

FILE: design/rotate_flip_scale_coordinate_mapper_top.sv
// ============================================================================
// Rotate, flip and scale coordinate mapper
// Maps an output pixel coordinate to a fixed point source coordinate through
// a viewport scale, a quarter turn rotation and mirroring.
// ============================================================================
// A transaction is taken on every cycle in which start is high; busy is always
// low. Its result appears on src_x_o, src_y_o and inside_res_o for one cycle,
// marked by res_valid_o, in the order of the starts. The pipeline runs through
// an adder stage, a multiplier stage, the two long dividers, which resolve one
// quotient bit per register stage, and three stages of rotation, mirroring and
// saturation. Throughput is one transaction per clock. The receiver must take
// every result in the cycle it is shown. Configuration registers may only be
// written while no transaction is in flight, as the pipeline reads them live.
`include "assert_macros.svh"

module rotate_flip_scale_coordinate_mapper_top #(
  parameter int unsigned COORD_BITS = rfsc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rfsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rfsc_pkg::ADDR_W-1:0]         paddr,
  input  logic [rfsc_pkg::DATA_W-1:0]         pwdata,
  output logic [rfsc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // Command side.
  input  logic                                start,
  output logic                                busy,
  input  logic [COORD_BITS-1:0]               out_x_i,
  input  logic [COORD_BITS-1:0]               out_y_i,
  // Result side.
  output logic                                res_valid_o,
  output logic signed [rfsc_pkg::OUT_W-1:0]   src_x_o,
  output logic signed [rfsc_pkg::OUT_W-1:0]   src_y_o,
  output logic                                inside_res_o
);

  import rfsc_pkg::*;

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned NW  = 2 * DW;
  localparam int unsigned QW  = NW + FRAC_BITS;
  localparam int unsigned PW  = QW + 2;
  localparam int unsigned LAT = QW + 5;

  localparam logic signed [PW-1:0] ONE_S   = $signed(PW'(1) << FRAC_BITS);
  localparam logic signed [PW-1:0] NEG_ONE = -ONE_S;
  localparam logic signed [PW-1:0] SAT_HI  = $signed(PW'((64'd1 << (OUT_W - 1)) - 64'd1));
  localparam logic signed [PW-1:0] SAT_LO  = ~SAT_HI;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0]         in_width_q, in_width_d;
  logic [DW-1:0]         in_height_q, in_height_d;
  logic [COORD_BITS-1:0] view_x_q, view_x_d;
  logic [COORD_BITS-1:0] view_y_q, view_y_d;
  logic [DW-1:0]         view_width_q, view_width_d;
  logic [DW-1:0]         view_height_q, view_height_d;
  logic [3:0]            orient_q, orient_d;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  // Register write decode.
  always_comb begin
    in_width_d    = in_width_q;
    in_height_d   = in_height_q;
    view_x_d      = view_x_q;
    view_y_d      = view_y_q;
    view_width_d  = view_width_q;
    view_height_d = view_height_q;
    orient_d      = orient_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_IN_WIDTH:    in_width_d    = pwdata[DW-1:0];
        REG_IN_HEIGHT:   in_height_d   = pwdata[DW-1:0];
        REG_VIEW_X:      view_x_d      = pwdata[COORD_BITS-1:0];
        REG_VIEW_Y:      view_y_d      = pwdata[COORD_BITS-1:0];
        REG_VIEW_WIDTH:  view_width_d  = pwdata[DW-1:0];
        REG_VIEW_HEIGHT: view_height_d = pwdata[DW-1:0];
        REG_ORIENT:      orient_d      = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q    <= DW'(1);
      in_height_q   <= DW'(1);
      view_x_q      <= '0;
      view_y_q      <= '0;
      view_width_q  <= DW'(1);
      view_height_q <= DW'(1);
      orient_q      <= '0;
    end else begin
      in_width_q    <= in_width_d;
      in_height_q   <= in_height_d;
      view_x_q      <= view_x_d;
      view_y_q      <= view_y_d;
      view_width_q  <= view_width_d;
      view_height_q <= view_height_d;
      orient_q      <= orient_d;
    end
  end

  // Register read mux.
  always_comb begin
    case (cfg_idx)
      REG_IN_WIDTH:    prdata = DATA_W'(in_width_q);
      REG_IN_HEIGHT:   prdata = DATA_W'(in_height_q);
      REG_VIEW_X:      prdata = DATA_W'(view_x_q);
      REG_VIEW_Y:      prdata = DATA_W'(view_y_q);
      REG_VIEW_WIDTH:  prdata = DATA_W'(view_width_q);
      REG_VIEW_HEIGHT: prdata = DATA_W'(view_height_q);
      REG_ORIENT:      prdata = DATA_W'(orient_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Decoded orientation and shared constants
  // --------------------------------------------------------------------------
  logic                 quarter;
  logic                 flip_x;
  logic                 flip_y;
  logic [DW-1:0]        num_x;
  logic [DW-1:0]        num_y;
  logic [DW-1:0]        den_x;
  logic [DW-1:0]        den_y;
  logic signed [PW-1:0] w_fix;
  logic signed [PW-1:0] h_fix;
  logic signed [PW-1:0] w_m1;
  logic signed [PW-1:0] h_m1;

  // Under a quarter turn the source dimensions and the flips are exchanged.
  assign quarter = orient_q[0];
  assign flip_x  = quarter ? orient_q[3] : orient_q[2];
  assign flip_y  = quarter ? orient_q[2] : orient_q[3];
  assign num_x   = quarter ? in_height_q : in_width_q;
  assign num_y   = quarter ? in_width_q : in_height_q;
  assign den_x   = (view_width_q == '0) ? DW'(1) : view_width_q;
  assign den_y   = (view_height_q == '0) ? DW'(1) : view_height_q;
  assign w_fix   = $signed(PW'({in_width_q, {FRAC_BITS{1'b0}}}));
  assign h_fix   = $signed(PW'({in_height_q, {FRAC_BITS{1'b0}}}));
  assign w_m1    = w_fix - ONE_S;
  assign h_m1    = h_fix - ONE_S;

  // --------------------------------------------------------------------------
  // Stage A: viewport offset
  // --------------------------------------------------------------------------
  logic          accept;
  logic          a_valid_q;
  logic [DW-1:0] a_sum_x_q, a_sum_x_d;
  logic [DW-1:0] a_sum_y_q, a_sum_y_d;

  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign a_sum_x_d = DW'(out_x_i) + DW'(view_x_q);
  assign a_sum_y_d = DW'(out_y_i) + DW'(view_y_q);

  // --------------------------------------------------------------------------
  // Stage B: multiply by the source dimension
  // --------------------------------------------------------------------------
  logic          b_valid_q;
  logic [NW-1:0] b_prod_x_q, b_prod_x_d;
  logic [NW-1:0] b_prod_y_q, b_prod_y_d;

  assign b_prod_x_d = NW'(a_sum_x_q) * NW'(num_x);
  assign b_prod_y_d = NW'(a_sum_y_q) * NW'(num_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sum_x_q  <= a_sum_x_d;
    a_sum_y_q  <= a_sum_y_d;
    b_prod_x_q <= b_prod_x_d;
    b_prod_y_q <= b_prod_y_d;
  end

  // --------------------------------------------------------------------------
  // Division by the viewport dimension
  // --------------------------------------------------------------------------
  logic          div_x_valid;
  logic          div_y_valid;
  logic [QW-1:0] quo_x;
  logic [QW-1:0] quo_y;

  rfsc_div #(
    .NUM_W     (NW),
    .DEN_W     (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .num_i   (b_prod_x_q),
    .den_i   (den_x),
    .valid_o (div_x_valid),
    .quo_o   (quo_x)
  );

  rfsc_div #(
    .NUM_W     (NW),
    .DEN_W     (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .num_i   (b_prod_y_q),
    .den_i   (den_y),
    .valid_o (div_y_valid),
    .quo_o   (quo_y)
  );

  // --------------------------------------------------------------------------
  // Stage C: rotation
  // --------------------------------------------------------------------------
  logic                 c_valid_q;
  logic signed [PW-1:0] c_px_q, c_px_d;
  logic signed [PW-1:0] c_py_q, c_py_d;
  logic signed [PW-1:0] sx_s;
  logic signed [PW-1:0] sy_s;
  logic signed [PW-1:0] sx_int;
  logic signed [PW-1:0] sy_int;

  assign sx_s   = $signed(PW'(quo_x));
  assign sy_s   = $signed(PW'(quo_y));
  assign sx_int = $signed(PW'({quo_x[QW-1:FRAC_BITS], {FRAC_BITS{1'b0}}}));
  assign sy_int = $signed(PW'({quo_y[QW-1:FRAC_BITS], {FRAC_BITS{1'b0}}}));

  // Quarter turns drop the fraction before the axes are swapped.
  always_comb begin
    case (rot_e'(orient_q[1:0]))
      ROT_90: begin
        c_px_d = sy_int;
        c_py_d = h_m1 - sx_int;
      end
      ROT_180: begin
        c_px_d = w_m1 - sx_s;
        c_py_d = h_m1 - sy_s;
      end
      ROT_270: begin
        c_px_d = w_m1 - sy_int;
        c_py_d = sx_int;
      end
      default: begin
        c_px_d = sx_s;
        c_py_d = sy_s;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage D: mirroring
  // --------------------------------------------------------------------------
  logic                 d_valid_q;
  logic signed [PW-1:0] d_px_q, d_px_d;
  logic signed [PW-1:0] d_py_q, d_py_d;

  assign d_px_d = flip_x ? (w_m1 - c_px_q) : c_px_q;
  assign d_py_d = flip_y ? (h_m1 - c_py_q) : c_py_q;

  // --------------------------------------------------------------------------
  // Stage E: saturation and bounds check
  // --------------------------------------------------------------------------
  logic                    res_valid_q;
  logic signed [OUT_W-1:0] src_x_q, src_x_d;
  logic signed [OUT_W-1:0] src_y_q, src_y_d;
  logic                    inside_q, inside_d;
  logic                    in_x;
  logic                    in_y;

  always_comb begin
    if (d_px_q > SAT_HI) begin
      src_x_d = SAT_HI[OUT_W-1:0];
    end else if (d_px_q < SAT_LO) begin
      src_x_d = SAT_LO[OUT_W-1:0];
    end else begin
      src_x_d = d_px_q[OUT_W-1:0];
    end
    if (d_py_q > SAT_HI) begin
      src_y_d = SAT_HI[OUT_W-1:0];
    end else if (d_py_q < SAT_LO) begin
      src_y_d = SAT_LO[OUT_W-1:0];
    end else begin
      src_y_d = d_py_q[OUT_W-1:0];
    end
  end

  // Truncation toward zero keeps anything above minus one at a column of zero
  // or more, so the check needs no separate truncation.
  assign in_x     = (d_px_q > NEG_ONE) && (d_px_q < w_fix) && (in_width_q != '0);
  assign in_y     = (d_py_q > NEG_ONE) && (d_py_q < h_fix) && (in_height_q != '0);
  assign inside_d = in_x & in_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      c_valid_q   <= div_x_valid & div_y_valid;
      d_valid_q   <= c_valid_q;
      res_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_px_q   <= c_px_d;
    c_py_q   <= c_py_d;
    d_px_q   <= d_px_d;
    d_py_q   <= d_py_d;
    src_x_q  <= src_x_d;
    src_y_q  <= src_y_d;
    inside_q <= inside_d;
  end

  assign res_valid_o  = res_valid_q;
  assign src_x_o      = src_x_q;
  assign src_y_o      = src_y_q;
  assign inside_res_o = inside_q;

  // Both dividers carry the same transactions in lock step.
  `ASSERT_ALWAYS(a_div_lockstep, clk_i, rst_ni, div_x_valid == div_y_valid, "dividers out of step")
  // Every result follows its transaction by the fixed pipeline latency.
  `ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, res_valid_o, $past(accept, LAT), "result without matching start")

endmodule
